@@ rtl/cfla_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfla_pkg: shared types and constants of the free-list allocator
// Heap geometry, status codes, header layout and sequencer states.
// ----------------------------------------------------------------------------
package cfla_pkg;

	localparam int TotalUnits = 1024;
	localparam int UnitBytes  = 16;
	localparam int IdxW       = 10;
	localparam int CntW       = 11;
	localparam int UbShift    = $clog2(UnitBytes);

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CntW-1:0] cnt_t;

	// Header: size in units, then next index.
	typedef struct packed {
		cnt_t size;
		idx_t next;
	} hdr_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOSPC = 2'd1;
	localparam logic [1:0] ST_NOFIT = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam cnt_t Cap = cnt_t'(TotalUnits - 2);

	typedef enum logic [4:0] {
		S_IDLE, S_INIT0, S_INIT1,
		S_A_HD, S_A_RD, S_A_CHK, S_A_WR,
		S_F_RD, S_F_CHK,
		S_F_RDB, S_F_RDN, S_F_WRB, S_F_RDP, S_F_WRP,
		S_U_RD1, S_U_RD2,
		S_OUT
	} state_t;

	// Memory command from the sequencer.
	typedef struct packed {
		logic we;
		idx_t waddr;
		hdr_t wdata;
		idx_t raddr;
	} mem_cmd_t;

endpackage
`default_nettype wire

@@ rtl/cfla_hdr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfla_hdr_ram: header store
// One write port and one registered read port over all heap units.
// ----------------------------------------------------------------------------
module cfla_hdr_ram
	import cfla_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_cmd_t cmd,
	output hdr_t          rdata
);

	hdr_t mem_q [TotalUnits];

	// Write, then registered read.
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[cmd.waddr] <= cmd.wdata;
		end
		rdata <= mem_q[cmd.raddr];
	end

endmodule
`default_nettype wire

@@ rtl/coalescing_free_list_allocator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_free_list_allocator_unit: next-fit heap allocator with merging
// Walks an address-ordered circular free list, one header read per step.
// ----------------------------------------------------------------------------
// Channel  | Dir | tdata fields (low first)                   | tuser
// s_axis   | in  | size_bytes[15:0], block_index[25:16]       | req_type
// m_axis   | out | status[1:0], payload_index[11:2],          | -
//          |     | free_units[21:12], unified[22]             |
// One request at a time. An allocate reads one list block per step, with an
// extra write when it splits a block and two init writes on the first
// allocation; a free searches the list block by block, then rewrites the
// headers of the freed block and its predecessor; a rejected request goes
// straight to the result steps. Reset clears the control state; the header
// store is built on the first allocation that is not rejected.
// The result register holds while m_axis_tready is low, and the sequencer
// waits in its last step while an earlier result is still held.
// ----------------------------------------------------------------------------
module coalescing_free_list_allocator_unit
	import cfla_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // size_bytes, block_index
	input  wire logic        s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // status, payload_index, free_units, unified
);

	state_t state_q, state_d;
	mem_cmd_t cmd;
	hdr_t rd;

	cnt_t free_q, need_q;
	idx_t cur_q, last_q, curr_q, b_q, p_q, n_q;
	logic built_q;
	logic [IdxW:0] steps_q;
	hdr_t hb_q, hp_q;
	logic [1:0] status_q;
	idx_t pay_q;
	logic [23:0] out_q;
	logic ovalid_q;

	logic [16:0] need_c;
	assign need_c = 17'((32'(s_axis_tdata[15:0]) + 32'(UnitBytes - 1)) >> UbShift) + 17'd1;

	cnt_t rem_c;
	assign rem_c = rd.size - need_q;

	cnt_t bsum_c;
	assign bsum_c = cnt_t'(b_q) + hb_q.size;

	logic in_gap_c;
	always_comb begin
		in_gap_c = (b_q >= p_q && b_q < rd.next) ||
			(p_q >= rd.next && (b_q > p_q || b_q < rd.next));
	end

	cfla_hdr_ram u_ram (.clk(clk), .cmd(cmd), .rdata(rd));

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == REQ_ALLOC) begin
					if (s_axis_tdata[15:0] == 16'd0 || need_c > 17'(free_q)) state_d = S_U_RD1;
					else if (!built_q) state_d = S_INIT0;
					else state_d = S_A_HD;
				end else begin
					if (!built_q || s_axis_tdata[25:16] < 10'd2) state_d = S_U_RD1;
					else state_d = S_F_RD;
				end
			end
			S_INIT0: state_d = S_INIT1;
			S_INIT1: state_d = S_A_RD;
			S_A_HD:  state_d = S_A_CHK;
			S_A_RD:  state_d = S_A_CHK;
			S_A_CHK: begin
				if (rd.size > need_q) state_d = S_A_WR;
				else if (rd.size == need_q) state_d = S_U_RD1;
				else if (curr_q == cur_q || steps_q == (IdxW+1)'(TotalUnits)) state_d = S_U_RD1;
				else state_d = S_A_RD;
			end
			S_A_WR:  state_d = S_U_RD1;
			S_F_RD:  state_d = S_F_CHK;
			S_F_CHK: begin
				if (in_gap_c || steps_q == (IdxW+1)'(TotalUnits)) state_d = S_F_RDB;
				else state_d = S_F_RD;
			end
			S_F_RDB: state_d = S_F_RDN;
			S_F_RDN: state_d = S_F_WRB;
			S_F_WRB: state_d = S_F_RDP;
			S_F_RDP: state_d = S_F_WRP;
			S_F_WRP: state_d = S_U_RD1;
			S_U_RD1: state_d = S_U_RD2;
			S_U_RD2: state_d = S_OUT;
			S_OUT:   if (!ovalid_q || m_axis_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory commands.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.raddr = cur_q;
			S_INIT0: begin
				cmd.we = 1'b1; cmd.waddr = idx_t'(0);
				cmd.wdata = '{size: '0, next: idx_t'(1)};
			end
			S_INIT1: begin
				cmd.we = 1'b1; cmd.waddr = idx_t'(1);
				cmd.wdata = '{size: free_q, next: '0};
				cmd.raddr = idx_t'(1);
			end
			S_A_HD: cmd.raddr = rd.next;
			S_A_RD: cmd.raddr = curr_q;
			S_A_CHK: if (rd.size == need_q) begin
				cmd.we = 1'b1; cmd.waddr = last_q;
				cmd.wdata = '{size: hp_q.size, next: rd.next};
			end else if (rd.size > need_q) begin
				cmd.we = 1'b1; cmd.waddr = curr_q;
				cmd.wdata = '{size: rem_c, next: rd.next};
				cmd.raddr = curr_q + idx_t'(rem_c);
			end
			// The carved tail gets its own header; its next field is kept.
			S_A_WR: begin
				cmd.we = 1'b1; cmd.waddr = pay_q - idx_t'(1);
				cmd.wdata = '{size: need_q, next: rd.next};
			end
			S_F_RD:  cmd.raddr = p_q;
			S_F_RDB: cmd.raddr = b_q;
			S_F_RDN: cmd.raddr = n_q;
			S_F_WRB: begin
				cmd.we = 1'b1; cmd.waddr = b_q;
				if (bsum_c == cnt_t'(n_q))
					cmd.wdata = '{size: hb_q.size + rd.size, next: rd.next};
				else
					cmd.wdata = '{size: hb_q.size, next: n_q};
			end
			S_F_RDP: cmd.raddr = p_q;
			// The header of p is read fresh and the new header of b is held.
			S_F_WRP: begin
				cmd.we = 1'b1; cmd.waddr = p_q;
				if (cnt_t'(p_q) + rd.size == cnt_t'(b_q))
					cmd.wdata = '{size: rd.size + hb_q.size, next: hb_q.next};
				else
					cmd.wdata = '{size: rd.size, next: b_q};
			end
			S_U_RD1: cmd.raddr = cur_q;
			S_U_RD2: cmd.raddr = rd.next;
			S_OUT:   cmd.raddr = n_q;
			default: cmd = '0;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			free_q   <= Cap;
			cur_q    <= '0;
			built_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Result register: load when the slot is free, clear when taken.
			if (state_q == S_OUT && (!ovalid_q || m_axis_tready)) begin
				out_q <= {1'b0, built_q && (rd.next == cur_q), free_q[IdxW-1:0],
					pay_q, status_q};
				ovalid_q <= 1'b1;
			end else if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					need_q   <= cnt_t'(need_c);
					status_q <= ST_OK;
					pay_q    <= '0;
					steps_q  <= '0;
					last_q   <= cur_q;
					p_q      <= cur_q;
					b_q      <= s_axis_tdata[25:16] - idx_t'(1);
					if (s_axis_tuser == REQ_ALLOC) begin
						if (s_axis_tdata[15:0] == 16'd0 || need_c > 17'(free_q))
							status_q <= ST_NOSPC;
					end else if (!built_q || s_axis_tdata[25:16] < 10'd2) begin
						status_q <= ST_RANGE;
					end
				end
				S_INIT0: begin
					cur_q <= '0; built_q <= 1'b1; curr_q <= idx_t'(1);
					last_q <= '0; hp_q <= '{size: '0, next: idx_t'(1)};
				end
				S_INIT1: ;
				S_A_HD: begin
					hp_q   <= rd;
					curr_q <= rd.next;
				end
				S_A_CHK: begin
					if (rd.size >= need_q) begin
						cur_q  <= last_q;
						free_q <= free_q - need_q;
						pay_q  <= (rd.size == need_q) ? curr_q + idx_t'(1)
							: curr_q + idx_t'(rem_c) + idx_t'(1);
					end else if (curr_q == cur_q || steps_q == (IdxW+1)'(TotalUnits)) begin
						status_q <= ST_NOFIT;
					end else begin
						last_q  <= curr_q;
						hp_q    <= rd;
						curr_q  <= rd.next;
						steps_q <= steps_q + (IdxW+1)'(1);
					end
				end
				S_F_CHK: begin
					n_q <= rd.next;
					if (!in_gap_c && steps_q != (IdxW+1)'(TotalUnits)) begin
						p_q <= rd.next;
						steps_q <= steps_q + (IdxW+1)'(1);
					end
				end
				S_F_RDN: begin
					hb_q <= rd;
					free_q <= (rd.size >= Cap - free_q) ? Cap : free_q + rd.size;
				end
				S_F_WRB: hb_q <= cmd.wdata;
				S_F_WRP: cur_q <= p_q;
				S_U_RD2: n_q <= rd.next;
				default: ;
			endcase
		end
	end

	// The result word stays put while the receiver holds off.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

	// The free count never exceeds the heap capacity.
	a_free_cap: assert property (@(posedge clk) disable iff (!arst_n) free_q <= Cap);

	// The pad bit of the result word is always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[23]);

	// A request word is taken only while the sequencer is idle.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE);

endmodule
`default_nettype wire

@@ verif/coalescing_free_list_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// coalescing_free_list_allocator_unit_tb: self-checking bench of the allocator
// Drives allocate and free requests with random idling on both sides. It
// predicts every result word from its own copy of the heap headers and
// compares the results field by field in order.
// ----------------------------------------------------------------------------
module coalescing_free_list_allocator_unit_tb
	import cfla_pkg::*;
();

	class alloc_scoreboard;

		typedef struct {
			logic [1:0] status;
			idx_t       payload;
			idx_t       free_units;
			logic       unified;
		} result_t;

		int unsigned heap_size [TotalUnits];
		int unsigned heap_next [TotalUnits];
		int unsigned cursor;
		int unsigned free_cnt;
		bit          built;
		result_t     expected_q[$];
		int unsigned live_blocks[$];
		int          errors;

		function new();
			foreach (heap_size[i]) begin
				heap_size[i] = 0;
				heap_next[i] = 0;
			end
			cursor   = 0;
			free_cnt = TotalUnits - 2;
			built    = 0;
			errors   = 0;
		endfunction

		function int unsigned wrap(int unsigned i);
			return i % TotalUnits;
		endfunction

		function int unsigned nxt(int unsigned i);
			return wrap(heap_next[wrap(i)]);
		endfunction

		// Next-fit walk from the cursor, carving from the tail of the block found.
		function void allocate(int unsigned bytes, ref result_t r);
			int unsigned need, prev, curr;
			need = (bytes + UnitBytes - 1) / UnitBytes + 1;
			if (bytes == 0 || need > free_cnt) begin
				r.status = ST_NOSPC;
				return;
			end
			if (!built) begin
				heap_size[0] = 0;
				heap_size[1] = free_cnt;
				heap_next[1] = 0;
				heap_next[0] = 1;
				cursor       = 0;
				built        = 1;
			end
			prev = cursor;
			curr = nxt(prev);
			for (int unsigned n = 0; n <= TotalUnits; n++) begin
				if (heap_size[curr] >= need) begin
					if (heap_size[curr] == need) begin
						heap_next[prev] = nxt(curr);
					end else begin
						heap_size[curr] = heap_size[curr] - need;
						curr            = wrap(curr + heap_size[curr]);
						heap_size[curr] = need;
					end
					cursor     = prev;
					free_cnt  -= need;
					r.status   = ST_OK;
					r.payload  = idx_t'(curr + 1);
					live_blocks.push_back(curr + 1);
					return;
				end
				if (curr == cursor) break;
				prev = curr;
				curr = nxt(curr);
			end
			r.status = ST_NOFIT;
		endfunction

		// Address-ordered insert, merging with the neighbors on both sides.
		function void release_block(int unsigned idx, ref result_t r);
			int unsigned b, p, n, cap;
			cap = TotalUnits - 2;
			if (!built || idx < 2 || idx >= TotalUnits) begin
				r.status = ST_RANGE;
				return;
			end
			b        = idx - 1;
			free_cnt = (heap_size[b] >= cap - free_cnt) ? cap : free_cnt + heap_size[b];
			p = cursor;
			for (int unsigned s = 0; s < TotalUnits; s++) begin
				n = nxt(p);
				if (b >= p && b < n) break;
				if (p >= n && (b > p || b < n)) break;
				p = n;
			end
			if (b + heap_size[b] == nxt(p)) begin
				heap_size[b] = heap_size[b] + heap_size[nxt(p)];
				heap_next[b] = nxt(nxt(p));
			end else begin
				heap_next[b] = nxt(p);
			end
			if (p + heap_size[p] == b) begin
				heap_size[p] = heap_size[p] + heap_size[b];
				heap_next[p] = nxt(b);
			end else begin
				heap_next[p] = b;
			end
			cursor   = p;
			r.status = ST_OK;
			foreach (live_blocks[i]) begin
				if (live_blocks[i] == idx) begin
					live_blocks.delete(i);
					break;
				end
			end
		endfunction

		// Called for every request word taken by the block.
		function void note(logic req, int unsigned bytes, int unsigned idx);
			result_t r;
			r.status  = ST_OK;
			r.payload = '0;
			if (req == REQ_ALLOC) allocate(bytes, r);
			else release_block(idx, r);
			r.unified    = built && (nxt(nxt(cursor)) == cursor);
			r.free_units = idx_t'(free_cnt);
			expected_q.push_back(r);
		endfunction

		// Called for every result word taken from the block.
		function void check(logic [23:0] word);
			result_t r;
			if (expected_q.size() == 0) begin
				$error("result word 0x%06h arrived with nothing expected", word);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (word[1:0] !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, word[1:0]);
				errors++;
			end
			if (word[11:2] !== r.payload) begin
				$error("payload_index: expected %0d, got %0d", r.payload, word[11:2]);
				errors++;
			end
			if (word[21:12] !== r.free_units) begin
				$error("free_units: expected %0d, got %0d", r.free_units, word[21:12]);
				errors++;
			end
			if (word[22] !== r.unified) begin
				$error("unified: expected %0d, got %0d", r.unified, word[22]);
				errors++;
			end
		endfunction
	endclass

	localparam int CycleLimit = 8000000;
	localparam int RandomRequests = 520;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // size_bytes[15:0], block_index[25:16]
	logic        s_axis_tuser = 1'b0;  // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // status, payload_index, free_units, unified

	alloc_scoreboard sb;
	bit quiet_tail = 0;
	bit long_hold_req = 0;
	int hold_cnt = 0;
	int cycle_cnt = 0;

	coalescing_free_list_allocator_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("coalescing_free_list_allocator_unit_tb failed");
			$finish;
		end
	end

	// Result side: check each taken word, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
			if (long_hold_req && hold_cnt == 0) begin
				long_hold_req <= 0;
				hold_cnt      <= 300;
				m_axis_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt      <= hold_cnt - 1;
				m_axis_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				hold_cnt      <= $urandom_range(1, 18) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one request word and hold it until taken, then maybe go idle.
	task automatic send(logic req, int unsigned bytes, int unsigned idx);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {6'd0, idx[9:0], bytes[15:0]};
		do @(posedge clk); while (!s_axis_tready);
		sb.note(req, bytes & 32'hFFFF, idx & 32'h3FF);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic free_random_live();
		int k;
		k = $urandom_range(0, sb.live_blocks.size() - 1);
		send(REQ_FREE, $urandom, sb.live_blocks[k]);
	endtask

	task automatic random_request();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45 && sb.live_blocks.size() != 0) begin
			free_random_live();
		end else if (roll < 48) begin
			send(REQ_FREE, $urandom, $urandom_range(0, 1));
		end else if (roll < 51) begin
			send(REQ_ALLOC, 0, $urandom);
		end else if (roll < 55) begin
			send(REQ_ALLOC, $urandom_range(0, 65535), $urandom);
		end else if (roll < 59 && sb.free_cnt > 1) begin
			// Ask for exactly what is left, a whole-block fit when unfragmented.
			send(REQ_ALLOC, (sb.free_cnt - 1) * UnitBytes, $urandom);
		end else if (roll < 72) begin
			send(REQ_ALLOC, $urandom_range(257, 4000), $urandom);
		end else begin
			send(REQ_ALLOC, $urandom_range(1, 256), $urandom);
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: free before build, size extremes, bounds of the free index.
		send(REQ_FREE, 0, 5);
		send(REQ_ALLOC, 0, 0);
		send(REQ_ALLOC, 16'hFFFF, 10'h3FF);
		send(REQ_ALLOC, 1, 0);
		send(REQ_ALLOC, 16, 0);
		send(REQ_ALLOC, 17, 0);
		send(REQ_ALLOC, 1000, 0);
		send(REQ_ALLOC, 4095, 0);
		send(REQ_FREE, 0, 0);
		send(REQ_FREE, 0, 1);
		send(REQ_FREE, 0, sb.live_blocks[1]);
		send(REQ_FREE, 0, sb.live_blocks[2]);
		send(REQ_FREE, 0, sb.live_blocks[0]);
		send(REQ_ALLOC, (sb.free_cnt - 1) * UnitBytes, 0);
		send(REQ_ALLOC, 2000, 0);
		send(REQ_ALLOC, (sb.free_cnt - 1) * UnitBytes, 0);
		send(REQ_ALLOC, 1, 0);
		while (sb.live_blocks.size() != 0) send(REQ_FREE, 0, sb.live_blocks[0]);

		// Pause with everything delivered, then a long receiver stall.
		drain();
		@(posedge clk);
		long_hold_req <= 1;
		for (int i = 0; i < RandomRequests; i++) begin
			if (i == RandomRequests - 60) quiet_tail = 1;
			random_request();
		end

		// Double free at the very end exercises the saturating free count.
		if (sb.live_blocks.size() != 0) begin
			int unsigned victim;
			victim = sb.live_blocks[0];
			send(REQ_FREE, 0, victim);
			send(REQ_FREE, 0, victim);
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("coalescing_free_list_allocator_unit_tb passed");
		end else begin
			$display("coalescing_free_list_allocator_unit_tb failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cfla_pkg.sv
rtl/cfla_hdr_ram.sv
rtl/coalescing_free_list_allocator_unit.sv
verif/coalescing_free_list_allocator_unit_tb.sv
